// File: src/mrds_pkg.sv
`timescale 1ns / 1ps

package mrds_pkg;

	localparam int unsigned SEGMENT_BYTES_DEF = 256;
	localparam int unsigned MAX_SPAN_DEF      = 1048576;

	localparam logic [2:0] KIND_SET_REGION = 3'd0;
	localparam logic [2:0] KIND_DUMP_NEXT  = 3'd1;
	localparam logic [2:0] KIND_DUMP_INDEX = 3'd2;
	localparam logic [2:0] KIND_DUMP_ONE   = 3'd3;
	localparam logic [2:0] KIND_SET_DEST   = 3'd4;
	localparam logic [2:0] KIND_COPY_STEP  = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CONTEXT = 2'd1;
	localparam logic [1:0] ST_PARAM   = 2'd2;

	localparam logic [1:0] FLAG_CONT   = 2'd0;
	localparam logic [1:0] FLAG_FIRST  = 2'd1;
	localparam logic [1:0] FLAG_LAST   = 2'd2;
	localparam logic [1:0] FLAG_SINGLE = 2'd3;

	localparam logic [7:0] REPEAT_LIMIT   = 8'd8;
	localparam logic [7:0] COUNTER_RESET  = 8'hff;
	localparam logic [15:0] SEQUENCE_ZERO = 16'h0000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] region_begin;
		logic [31:0] region_end;
		logic [7:0]  category;
		logic [7:0]  repeat_request;
		logic [15:0] segment_index;
		logic [31:0] target_address;
		logic [31:0] step_bytes;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        segment_valid;
		logic [31:0] read_address;
		logic [31:0] segment_length;
		logic [1:0]  sequence_flag;
		logic [7:0]  unit_counter;
		logic [15:0] unit_sequence;
		logic [23:0] unit_length;
		logic [7:0]  category_out;
		logic [2:0]  send_count;
		logic [31:0] write_address;
	} result_t;

endpackage

// File: src/memory_region_dump_segmenter_core.sv
`timescale 1ns / 1ps

// Memory region dump segmenter.
// Commands arrive on the in channel (in_valid / in_ready with the command
// fields); one descriptor leaves on the out channel (out_valid / out_ready)
// for every command, in order, with status and, when segment_valid is set,
// the read (and for copies the write) descriptor plus dump header fields.
// A command transferred on the in channel passes through the input register
// and then the result register before it is visible on the out channel.
// Throughput: one command per cycle; both register stages advance together
// whenever the result register is empty or being taken.
// When the receiver stalls, the result register holds its descriptor, the
// input register holds one more command, and in_ready falls once both are
// occupied.
// Reset clears both stages and the region, copy and sequence state; the data
// unit counter source restarts so that the first assigned counter is zero.
module memory_region_dump_segmenter_core #(
	parameter int unsigned SEGMENT_BYTES = mrds_pkg::SEGMENT_BYTES_DEF,
	parameter int unsigned MAX_SPAN      = mrds_pkg::MAX_SPAN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [31:0] region_begin,
	input  logic [31:0] region_end,
	input  logic [7:0]  category,
	input  logic [7:0]  repeat_request,
	input  logic [15:0] segment_index,
	input  logic [31:0] target_address,
	input  logic [31:0] step_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        segment_valid,
	output logic [31:0] read_address,
	output logic [31:0] segment_length,
	output logic [1:0]  sequence_flag,
	output logic [7:0]  unit_counter,
	output logic [15:0] unit_sequence,
	output logic [23:0] unit_length,
	output logic [7:0]  category_out,
	output logic [2:0]  send_count,
	output logic [31:0] write_address
);

	logic              valid_s1;
	mrds_pkg::cmd_t    cmd_s1;
	logic              out_valid_q;
	mrds_pkg::result_t res_q;
	mrds_pkg::result_t res;
	logic              advance;
	logic              in_xfer;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1 <= '{kind: kind, region_begin: region_begin, region_end: region_end,
				category: category, repeat_request: repeat_request,
				segment_index: segment_index, target_address: target_address,
				step_bytes: step_bytes};
		end
		if (advance) begin
			res_q <= res;
		end
	end

	mrds_engine #(
		.SEGMENT_BYTES(SEGMENT_BYTES),
		.MAX_SPAN(MAX_SPAN)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.cmd(cmd_s1),
		.res(res)
	);

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign segment_valid  = res_q.segment_valid;
	assign read_address   = res_q.read_address;
	assign segment_length = res_q.segment_length;
	assign sequence_flag  = res_q.sequence_flag;
	assign unit_counter   = res_q.unit_counter;
	assign unit_sequence  = res_q.unit_sequence;
	assign unit_length    = res_q.unit_length;
	assign category_out   = res_q.category_out;
	assign send_count     = res_q.send_count;
	assign write_address  = res_q.write_address;

	// a held command is never dropped while the result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |=> valid_s1)
		else $error("pending command lost");

	// ready only drops with both stages occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q))
		else $error("ready low with a free stage");

	// fields without a descriptor stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.segment_valid) |->
		(res_q.read_address == '0 && res_q.segment_length == '0 &&
		 res_q.sequence_flag == mrds_pkg::FLAG_CONT && res_q.write_address == '0))
		else $error("stray descriptor fields");

	// status never carries an unused code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.status != 2'd3))
		else $error("bad status code");

endmodule

// File: src/mrds_engine.sv
`timescale 1ns / 1ps

module mrds_engine #(
	parameter int unsigned SEGMENT_BYTES = mrds_pkg::SEGMENT_BYTES_DEF,
	parameter int unsigned MAX_SPAN      = mrds_pkg::MAX_SPAN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  mrds_pkg::cmd_t   cmd,
	output mrds_pkg::result_t res
);

	localparam int unsigned SEG_W = $clog2(SEGMENT_BYTES + 1);
	localparam int unsigned OFF_W = 16 + SEG_W;
	localparam int unsigned RP_W  = 34;
	localparam logic [OFF_W-1:0] SEG_OFF = OFF_W'(SEGMENT_BYTES);
	localparam logic [31:0] SEG_32  = 32'(SEGMENT_BYTES);
	localparam logic [32:0] SPAN_33 = 33'(MAX_SPAN);

	logic [31:0] begin_q;
	logic [31:0] end_q;
	logic [23:0] unit_size_q;
	logic [15:0] next_seq_q;
	logic [7:0]  region_counter_q;
	logic [7:0]  counter_source_q;
	logic [31:0] dest_q;
	logic [31:0] copy_ptr_q;

	logic [31:0] begin_d;
	logic [31:0] end_d;
	logic [23:0] unit_size_d;
	logic [15:0] next_seq_d;
	logic [7:0]  region_counter_d;
	logic [7:0]  counter_source_d;
	logic [31:0] dest_d;
	logic [31:0] copy_ptr_d;

	logic [15:0]      seq;
	logic [OFF_W-1:0] off;
	logic [RP_W-1:0]  rp;
	logic             rp_inside;
	logic [31:0]      diff;
	logic             clipped;
	logic [31:0]      seg_len;
	logic [1:0]       flag;
	logic             reps_bad;
	logic [31:0]      span;
	logic [7:0]       counter_inc;
	logic             cp_inside;
	logic [32:0]      copy_end;
	logic [31:0]      copy_len;

	assign seq         = (cmd.kind == mrds_pkg::KIND_DUMP_INDEX) ? cmd.segment_index : next_seq_q;
	assign off         = OFF_W'(seq) * SEG_OFF;
	assign rp          = RP_W'(begin_q) + RP_W'(off);
	assign rp_inside   = rp < RP_W'(end_q);
	assign diff        = end_q - rp[31:0];
	assign clipped     = diff > SEG_32;
	assign seg_len     = clipped ? SEG_32 : diff;
	assign reps_bad    = cmd.repeat_request >= mrds_pkg::REPEAT_LIMIT;
	assign span        = cmd.region_end - cmd.region_begin;
	assign counter_inc = counter_source_q + 8'd1;
	assign cp_inside   = (copy_ptr_q >= begin_q) && (copy_ptr_q < end_q);
	assign copy_end    = {1'b0, copy_ptr_q} + {1'b0, cmd.step_bytes};
	assign copy_len    = (copy_end > {1'b0, end_q}) ? (end_q - copy_ptr_q) : cmd.step_bytes;

	always_comb begin
		if ({8'd0, unit_size_q} <= SEG_32) begin
			flag = mrds_pkg::FLAG_SINGLE;
		end else if (off == '0) begin
			flag = mrds_pkg::FLAG_FIRST;
		end else if (!clipped) begin
			flag = mrds_pkg::FLAG_LAST;
		end else begin
			flag = mrds_pkg::FLAG_CONT;
		end
	end

	always_comb begin
		res              = '0;
		begin_d          = begin_q;
		end_d            = end_q;
		unit_size_d      = unit_size_q;
		next_seq_d       = next_seq_q;
		region_counter_d = region_counter_q;
		counter_source_d = counter_source_q;
		dest_d           = dest_q;
		copy_ptr_d       = copy_ptr_q;
		case (cmd.kind)
			mrds_pkg::KIND_SET_REGION: begin
				if (cmd.region_begin > cmd.region_end) begin
					res.status = mrds_pkg::ST_CONTEXT;
				end else if ({1'b0, span} > SPAN_33) begin
					res.status = mrds_pkg::ST_PARAM;
				end else begin
					begin_d          = cmd.region_begin;
					end_d            = cmd.region_end;
					unit_size_d      = span[23:0];
					next_seq_d       = mrds_pkg::SEQUENCE_ZERO;
					region_counter_d = counter_inc;
					counter_source_d = counter_inc;
				end
			end
			mrds_pkg::KIND_DUMP_NEXT, mrds_pkg::KIND_DUMP_INDEX: begin
				if (reps_bad) begin
					res.status = mrds_pkg::ST_PARAM;
				end else if (!rp_inside) begin
					// exhausted region on dump next is not an error
					if (cmd.kind == mrds_pkg::KIND_DUMP_INDEX) begin
						res.status = mrds_pkg::ST_CONTEXT;
					end
				end else begin
					res.segment_valid  = 1'b1;
					res.read_address   = rp[31:0];
					res.segment_length = seg_len;
					res.sequence_flag  = flag;
					res.unit_counter   = region_counter_q;
					res.unit_sequence  = seq;
					res.unit_length    = unit_size_q;
					res.category_out   = cmd.category;
					res.send_count     = cmd.repeat_request[2:0];
					next_seq_d         = seq + 16'd1;
				end
			end
			mrds_pkg::KIND_DUMP_ONE: begin
				if (reps_bad) begin
					res.status = mrds_pkg::ST_PARAM;
				end else begin
					res.segment_valid  = 1'b1;
					res.read_address   = cmd.target_address;
					res.segment_length = SEG_32;
					res.sequence_flag  = mrds_pkg::FLAG_SINGLE;
					res.unit_counter   = counter_inc;
					res.unit_length    = SEG_32[23:0];
					res.category_out   = cmd.category;
					res.send_count     = cmd.repeat_request[2:0];
					counter_source_d   = counter_inc;
				end
			end
			mrds_pkg::KIND_SET_DEST: begin
				if ((cmd.target_address >= begin_q) && (cmd.target_address < end_q)) begin
					res.status = mrds_pkg::ST_PARAM;
				end else begin
					dest_d     = cmd.target_address;
					copy_ptr_d = begin_q;
				end
			end
			mrds_pkg::KIND_COPY_STEP: begin
				if (cp_inside) begin
					res.segment_valid  = 1'b1;
					res.read_address   = copy_ptr_q;
					res.segment_length = copy_len;
					res.write_address  = dest_q + (copy_ptr_q - begin_q);
					copy_ptr_d         = copy_ptr_q + copy_len;
				end
			end
			default: begin
				res.status = mrds_pkg::ST_CONTEXT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q          <= '0;
			end_q            <= '0;
			unit_size_q      <= '0;
			next_seq_q       <= '0;
			region_counter_q <= '0;
			counter_source_q <= mrds_pkg::COUNTER_RESET;
			dest_q           <= '0;
			copy_ptr_q       <= '0;
		end else if (fire) begin
			begin_q          <= begin_d;
			end_q            <= end_d;
			unit_size_q      <= unit_size_d;
			next_seq_q       <= next_seq_d;
			region_counter_q <= region_counter_d;
			counter_source_q <= counter_source_d;
			dest_q           <= dest_d;
			copy_ptr_q       <= copy_ptr_d;
		end
	end

	// the region is only ever stored in order
	assert property (@(posedge clk) disable iff (!arst_n) begin_q <= end_q)
		else $error("region begin above end");

	// a descriptor never comes with an error status
	assert property (@(posedge clk) disable iff (!arst_n)
		res.segment_valid |-> (res.status == mrds_pkg::ST_OK))
		else $error("descriptor with error status");

	// the data unit counter only moves on a fired command
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(counter_source_q))
		else $error("counter moved without a command");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam logic [63:0] SEG_BYTES = 64'(mrds_pkg::SEGMENT_BYTES_DEF);
	localparam logic [31:0] SPAN_LIMIT = 32'(mrds_pkg::MAX_SPAN_DEF);
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;
	localparam int ITEM_TARGET = 1800;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;

	class dump_scoreboard;
		logic [31:0] region_lo, region_hi, dest_base, copy_ptr;
		logic [23:0] span_bytes;
		logic [15:0] seq_next;
		logic [7:0] unit_id, unit_id_src;
		mrds_pkg::result_t expected_q[$];
		int err_count;

		function new();
			region_lo = '0;
			region_hi = '0;
			dest_base = '0;
			copy_ptr = '0;
			span_bytes = '0;
			seq_next = '0;
			unit_id = '0;
			unit_id_src = mrds_pkg::COUNTER_RESET;
			err_count = 0;
		endfunction

		function logic [7:0] next_unit_id();
			unit_id_src = unit_id_src + 8'd1;
			return unit_id_src;
		endfunction

		function logic [63:0] seg_base(logic [15:0] seq);
			return {32'd0, region_lo} + 64'(seq) * SEG_BYTES;
		endfunction

		function void emit_segment(inout mrds_pkg::result_t r, input logic [7:0] cat,
				input logic [7:0] reps);
			logic [63:0] rp, len;
			rp = seg_base(seq_next);
			if (rp >= {32'd0, region_hi})
				return;
			len = {32'd0, region_hi} - rp;
			if (len > SEG_BYTES)
				len = SEG_BYTES;
			if (64'(span_bytes) <= SEG_BYTES)
				r.sequence_flag = mrds_pkg::FLAG_SINGLE;
			else if (rp == {32'd0, region_lo})
				r.sequence_flag = mrds_pkg::FLAG_FIRST;
			else if (rp + len == {32'd0, region_hi})
				r.sequence_flag = mrds_pkg::FLAG_LAST;
			else
				r.sequence_flag = mrds_pkg::FLAG_CONT;
			r.segment_valid = 1'b1;
			r.read_address = rp[31:0];
			r.segment_length = len[31:0];
			r.unit_counter = unit_id;
			r.unit_sequence = seq_next;
			r.unit_length = span_bytes;
			r.category_out = cat;
			r.send_count = reps[2:0];
			seq_next = seq_next + 16'd1;
		endfunction

		function void note_command(mrds_pkg::cmd_t c);
			mrds_pkg::result_t r;
			logic [31:0] w;
			r = '0;
			case (c.kind)
			mrds_pkg::KIND_SET_REGION: begin
				if (c.region_begin > c.region_end) begin
					r.status = mrds_pkg::ST_CONTEXT;
				end else if (c.region_end - c.region_begin > SPAN_LIMIT) begin
					r.status = mrds_pkg::ST_PARAM;
				end else begin
					region_lo = c.region_begin;
					region_hi = c.region_end;
					w = c.region_end - c.region_begin;
					span_bytes = w[23:0];
					seq_next = mrds_pkg::SEQUENCE_ZERO;
					unit_id = next_unit_id();
				end
			end
			mrds_pkg::KIND_DUMP_NEXT: begin
				if (c.repeat_request >= mrds_pkg::REPEAT_LIMIT)
					r.status = mrds_pkg::ST_PARAM;
				else
					emit_segment(r, c.category, c.repeat_request);
			end
			mrds_pkg::KIND_DUMP_INDEX: begin
				if (c.repeat_request >= mrds_pkg::REPEAT_LIMIT) begin
					r.status = mrds_pkg::ST_PARAM;
				end else if (seg_base(c.segment_index) < {32'd0, region_hi}) begin
					seq_next = c.segment_index;
					emit_segment(r, c.category, c.repeat_request);
				end else begin
					r.status = mrds_pkg::ST_CONTEXT;
				end
			end
			mrds_pkg::KIND_DUMP_ONE: begin
				if (c.repeat_request >= mrds_pkg::REPEAT_LIMIT) begin
					r.status = mrds_pkg::ST_PARAM;
				end else begin
					r.segment_valid = 1'b1;
					r.read_address = c.target_address;
					r.segment_length = SEG_BYTES[31:0];
					r.sequence_flag = mrds_pkg::FLAG_SINGLE;
					r.unit_counter = next_unit_id();
					r.unit_sequence = mrds_pkg::SEQUENCE_ZERO;
					r.unit_length = SEG_BYTES[23:0];
					r.category_out = c.category;
					r.send_count = c.repeat_request[2:0];
				end
			end
			mrds_pkg::KIND_SET_DEST: begin
				if (c.target_address >= region_lo && c.target_address < region_hi) begin
					r.status = mrds_pkg::ST_PARAM;
				end else begin
					dest_base = c.target_address;
					copy_ptr = region_lo;
				end
			end
			mrds_pkg::KIND_COPY_STEP: begin
				if (copy_ptr >= region_lo && copy_ptr < region_hi) begin
					w = c.step_bytes;
					if ({32'd0, copy_ptr} + {32'd0, w} > {32'd0, region_hi})
						w = region_hi - copy_ptr;
					r.segment_valid = 1'b1;
					r.read_address = copy_ptr;
					r.segment_length = w;
					r.write_address = dest_base + (copy_ptr - region_lo);
					copy_ptr = copy_ptr + w;
				end
			end
			default: r.status = mrds_pkg::ST_CONTEXT;
			endcase
			expected_q.push_back(r);
		endfunction

		function void cmp(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, e, a);
				err_count++;
			end
		endfunction

		function void check_result(mrds_pkg::result_t a);
			mrds_pkg::result_t e;
			if (expected_q.size() == 0) begin
				$error("descriptor transfer with nothing outstanding");
				err_count++;
				return;
			end
			e = expected_q.pop_front();
			cmp("status", 32'(e.status), 32'(a.status));
			cmp("segment_valid", 32'(e.segment_valid), 32'(a.segment_valid));
			cmp("read_address", e.read_address, a.read_address);
			cmp("segment_length", e.segment_length, a.segment_length);
			cmp("sequence_flag", 32'(e.sequence_flag), 32'(a.sequence_flag));
			cmp("unit_counter", 32'(e.unit_counter), 32'(a.unit_counter));
			cmp("unit_sequence", 32'(e.unit_sequence), 32'(a.unit_sequence));
			cmp("unit_length", 32'(e.unit_length), 32'(a.unit_length));
			cmp("category_out", 32'(e.category_out), 32'(a.category_out));
			cmp("send_count", 32'(e.send_count), 32'(a.send_count));
			cmp("write_address", e.write_address, a.write_address);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_ready, out_valid, out_ready;
	mrds_pkg::cmd_t cur;
	mrds_pkg::result_t got;
	logic [1:0] status, sequence_flag;
	logic segment_valid;
	logic [31:0] read_address, segment_length, write_address;
	logic [7:0] unit_counter, category_out;
	logic [15:0] unit_sequence;
	logic [23:0] unit_length;
	logic [2:0] send_count;

	dump_scoreboard sb = new();
	int burst_left = 0;
	int sent = 0;
	int cycles = 0;
	bit hold_req = 1'b0;

	assign got = {status, segment_valid, read_address, segment_length, sequence_flag,
		unit_counter, unit_sequence, unit_length, category_out, send_count, write_address};

	memory_region_dump_segmenter_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(cur.kind),
		.region_begin(cur.region_begin),
		.region_end(cur.region_end),
		.category(cur.category),
		.repeat_request(cur.repeat_request),
		.segment_index(cur.segment_index),
		.target_address(cur.target_address),
		.step_bytes(cur.step_bytes),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.segment_valid(segment_valid),
		.read_address(read_address),
		.segment_length(segment_length),
		.sequence_flag(sequence_flag),
		.unit_counter(unit_counter),
		.unit_sequence(unit_sequence),
		.unit_length(unit_length),
		.category_out(category_out),
		.send_count(send_count),
		.write_address(write_address)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_command(cur);
			if (out_valid && out_ready)
				sb.check_result(got);
		end
	end

	// receiver: changing stall patterns, plus one long hold on request
	initial begin
		int mode, mode_left;
		mode = 0;
		mode_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
			0: out_ready = 1'b1;
			1: out_ready = 1'($urandom_range(0, 1));
			2: out_ready = ($urandom_range(0, 3) == 0);
			default: out_ready = ~out_ready;
			endcase
		end
	end

	function automatic mrds_pkg::cmd_t rand_cmd();
		mrds_pkg::cmd_t c;
		c.kind = 3'($urandom_range(0, 7));
		c.region_begin = $urandom();
		c.region_end = $urandom();
		c.category = 8'($urandom());
		c.repeat_request = 8'($urandom());
		c.segment_index = 16'($urandom());
		c.target_address = $urandom();
		c.step_bytes = $urandom();
		return c;
	endfunction

	function automatic mrds_pkg::cmd_t region_cmd(logic [31:0] b, logic [31:0] e);
		mrds_pkg::cmd_t c;
		c = rand_cmd();
		c.kind = mrds_pkg::KIND_SET_REGION;
		c.region_begin = b;
		c.region_end = e;
		return c;
	endfunction

	function automatic mrds_pkg::cmd_t dump_cmd(logic [2:0] k, logic [15:0] idx);
		mrds_pkg::cmd_t c;
		c = rand_cmd();
		c.kind = k;
		c.segment_index = idx;
		c.repeat_request = 8'($urandom_range(0, 7));
		return c;
	endfunction

	function automatic mrds_pkg::cmd_t dest_cmd(logic [31:0] t);
		mrds_pkg::cmd_t c;
		c = rand_cmd();
		c.kind = mrds_pkg::KIND_SET_DEST;
		c.target_address = t;
		return c;
	endfunction

	function automatic mrds_pkg::cmd_t copy_cmd(logic [31:0] w);
		mrds_pkg::cmd_t c;
		c = rand_cmd();
		c.kind = mrds_pkg::KIND_COPY_STEP;
		c.step_bytes = w;
		return c;
	endfunction

	task automatic send(input mrds_pkg::cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		cur = c;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		sent++;
	endtask

	initial begin
		mrds_pkg::cmd_t c;
		logic [31:0] span, b, e;
		int nseg, steps, op;
		bit held, paused;
		held = 1'b0;
		paused = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cur = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed
		send(dump_cmd(mrds_pkg::KIND_DUMP_NEXT, 16'd0));
		send(copy_cmd(32'd100));
		c = rand_cmd();
		c.kind = KIND_SPARE_A;
		send(c);
		c.kind = KIND_SPARE_B;
		send(c);
		send(region_cmd(32'd100, 32'd50));
		send(region_cmd(32'd0, SPAN_LIMIT + 32'd1));
		send(region_cmd(32'h1000, 32'h1100));
		send(dump_cmd(mrds_pkg::KIND_DUMP_NEXT, 16'd0));
		send(dump_cmd(mrds_pkg::KIND_DUMP_NEXT, 16'd0));
		send(region_cmd(32'h2000, 32'h2200));
		send(dump_cmd(mrds_pkg::KIND_DUMP_NEXT, 16'd0));
		send(dump_cmd(mrds_pkg::KIND_DUMP_NEXT, 16'd0));
		send(region_cmd(32'hFFFFF000, 32'hFFFFFFFF));
		send(dump_cmd(mrds_pkg::KIND_DUMP_INDEX, 16'd15));
		send(dump_cmd(mrds_pkg::KIND_DUMP_INDEX, 16'd16));
		send(dump_cmd(mrds_pkg::KIND_DUMP_INDEX, 16'hFFFF));
		c = dump_cmd(mrds_pkg::KIND_DUMP_NEXT, 16'd0);
		c.repeat_request = mrds_pkg::REPEAT_LIMIT;
		send(c);
		c = dump_cmd(mrds_pkg::KIND_DUMP_INDEX, 16'd0);
		c.repeat_request = 8'hFF;
		send(c);
		c = dump_cmd(mrds_pkg::KIND_DUMP_ONE, 16'd0);
		c.repeat_request = 8'hFF;
		send(c);
		c = dump_cmd(mrds_pkg::KIND_DUMP_ONE, 16'd0);
		c.target_address = 32'hFFFFFFFF;
		c.repeat_request = mrds_pkg::REPEAT_LIMIT - 8'd1;
		c.category = 8'hFF;
		send(c);
		send(dest_cmd(32'hFFFFF800));
		send(dest_cmd(32'h10));
		send(copy_cmd(32'd0));
		send(copy_cmd(32'hFFFFFFFF));
		send(copy_cmd(32'd1));
		send(region_cmd(32'd0, SPAN_LIMIT));
		send(dump_cmd(mrds_pkg::KIND_DUMP_INDEX, 16'd4095));

		// random: mostly region sessions, some noise
		while (sent < ITEM_TARGET) begin
			if (!held && sent >= 600) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (!paused && sent >= 1200) begin
				@(negedge clk);
				in_valid = 1'b0;
				while (sb.pending() != 0) @(posedge clk);
				burst_left = 0;
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) < 3) begin
				steps = $urandom_range(1, 6);
				repeat (steps) send(rand_cmd());
			end else begin
				case ($urandom_range(0, 7))
				0: span = 0;
				1: span = $urandom_range(1, 255);
				2: span = 256;
				3: span = 256 * $urandom_range(2, 8);
				4, 5: span = $urandom_range(257, 3000);
				6: span = $urandom_range(1, mrds_pkg::MAX_SPAN_DEF);
				default: span = SPAN_LIMIT - 32'($urandom_range(0, 1));
				endcase
				b = ($urandom_range(0, 7) == 0) ?
					32'hFFFFFFFF - span - 32'($urandom_range(0, 3)) : $urandom();
				if (b > 32'hFFFFFFFF - span)
					b = 32'hFFFFFFFF - span;
				e = b + span;
				nseg = (span + 255) / 256;
				send(region_cmd(b, e));
				steps = $urandom_range(3, 14);
				repeat (steps) begin
					op = $urandom_range(0, 15);
					if (op <= 4) begin
						send(dump_cmd(mrds_pkg::KIND_DUMP_NEXT, 16'($urandom())));
					end else if (op <= 7) begin
						send(dump_cmd(mrds_pkg::KIND_DUMP_INDEX,
							16'($urandom_range(0, nseg))));
					end else if (op == 8) begin
						send(dump_cmd(mrds_pkg::KIND_DUMP_ONE, 16'($urandom())));
					end else if (op <= 10) begin
						if (span != 0 && $urandom_range(0, 3) == 0)
							send(dest_cmd(b + 32'($urandom_range(0, span - 1))));
						else
							send(dest_cmd(e + 32'($urandom_range(0, 1000))));
					end else if (op <= 14) begin
						if ($urandom_range(0, 9) == 0)
							send(copy_cmd($urandom()));
						else
							send(copy_cmd(32'($urandom_range(0, 700))));
					end else begin
						c = dump_cmd(3'($urandom_range(1, 3)), 16'($urandom_range(0, nseg)));
						c.repeat_request = 8'($urandom_range(8, 255));
						send(c);
					end
				end
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/mrds_pkg.sv
src/mrds_engine.sv
src/memory_region_dump_segmenter_core.sv
tb/testbench.sv
